FILE: hdl/brb_pkg.sv
// Shared types, constants and helpers for the byte ring buffer FIFO.
// No dependencies; used by the top level, its store and the port checker.
package brb_pkg;

  // Fixed by the request and result field widths
  localparam int CNT_W  = 9;
  localparam int BYTE_W = 8;
  localparam int REQ_W  = 3;

  // Default build-time sizes
  localparam int DEPTH_DEF   = 256;
  localparam int MAX_RUN_DEF = 64;

  // Capacity register value after reset
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(256);

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_PEEK   = 3'd2,
    REQ_RUN    = 3'd3,
    REQ_FILL   = 3'd4,
    REQ_CLEAR  = 3'd5,
    REQ_STATUS = 3'd6
  } req_t;

  // Clamp a written capacity into 1..depth
  function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] cap, input int depth);
    logic [CNT_W-1:0] res;
    res = cap;
    if (cap == '0) begin
      res = CNT_W'(1);
    end else if (int'(cap) > depth) begin
      res = CNT_W'(depth);
    end
    return res;
  endfunction

  // Advance a ring index by one, wrapping at the capacity
  function automatic logic [CNT_W-1:0] wrap_inc(input logic [CNT_W-1:0] idx,
                                                input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] inc;
    inc = idx + CNT_W'(1);
    return (inc >= cap) ? '0 : inc;
  endfunction

endpackage

FILE: hdl/byte_ring_buffer_fifo.sv
// Top level of the byte ring buffer FIFO: request decoder, ring pointers and result register.
// Depends on brb_pkg and brb_ram.
//
// Usage
//   Requests arrive on the in_ channel (req_type, data_in, amount) and are taken
//   by a transfer when in_valid is high and in_stall low. Results leave on the
//   out_ channel, one transfer per result, each with last marking the final one
//   of its request. The capacity register is written through cfg_wr_en and
//   cfg_wr_data; the user must write it only while the block is idle, which
//   the block itself does not enforce. A write also empties the queue.
//   One request is in progress at a time. A request is latched on its input
//   transfer and decided once the output register is free; its result is
//   then loaded into the output register. A pop run emits one byte per cycle
//   while the receiver does not stall; a fill makes the decision, does one
//   store write per cycle, then gives the report. The store has a single
//   write port and a registered read: the head entry is read continuously so
//   its byte is ready when the pop is decided.
//   Reset (synchronous, rst high) empties the queue, sets the capacity to 256
//   (clamped to DEPTH) and drops any pending result; the store is not cleared.
//   While the receiver stalls, the held result stays put and a run pauses; a new
//   request is taken only once the current one has issued all of its results.
module byte_ring_buffer_fifo #(
  parameter int DEPTH   = brb_pkg::DEPTH_DEF,
  parameter int MAX_RUN = brb_pkg::MAX_RUN_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // capacity register
  input  logic                         cfg_wr_en,
  input  logic [brb_pkg::CNT_W-1:0]    cfg_wr_data,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [brb_pkg::REQ_W-1:0]    req_type,
  input  logic [brb_pkg::BYTE_W-1:0]   data_in,
  input  logic [brb_pkg::CNT_W-1:0]    amount,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [brb_pkg::BYTE_W-1:0]   data_out,
  output logic                         accepted,
  output logic [brb_pkg::CNT_W-1:0]    fill_level,
  output logic [brb_pkg::CNT_W-1:0]    free_space,
  output logic                         is_empty,
  output logic                         is_full,
  output logic                         last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = brb_pkg::CNT_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_RUN    = 5'b00100,
    S_FILL   = 5'b01000,
    S_REPORT = 5'b10000
  } state_t;

  state_t state, state_next;

  // Ring pointers and capacity
  logic [CW-1:0] cap_eff;
  logic [CW-1:0] head, head_next;
  logic [CW-1:0] tail, tail_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] remaining, remaining_next;

  // Latched request
  logic [brb_pkg::REQ_W-1:0]  req;
  logic [brb_pkg::BYTE_W-1:0] din;
  logic [CW-1:0]              amt;

  // Store ports
  logic                       wr_en;
  logic [brb_pkg::BYTE_W-1:0] rd_data;

  // Result staging
  logic                       emit;
  logic [brb_pkg::BYTE_W-1:0] emit_data;
  logic                       emit_acc;
  logic                       emit_last;

  logic out_free, in_xfer;
  logic q_empty, q_full, run_ok, fill_ok;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign q_empty = (count == '0);
  assign q_full  = (count >= cap_eff);
  // A run needs enough stored bytes and stays within the burst limit
  assign run_ok  = (amt != '0) && (amt <= count) && (amt <= CW'(MAX_RUN));
  // A fill goes in whole or not at all
  assign fill_ok = (amt != '0) && (amt <= (cap_eff - count));

  brb_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(tail)),
    .wr_data (din),
    .rd_addr (AW'(head_next)),
    .rd_data (rd_data)
  );

  // Request sequencer
  always_comb begin
    state_next     = state;
    head_next      = head;
    tail_next      = tail;
    count_next     = count;
    remaining_next = remaining;
    wr_en          = 1'b0;
    emit           = 1'b0;
    emit_data      = '0;
    emit_acc       = 1'b0;
    emit_last      = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        // Decide only when the result has somewhere to go
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          unique case (req)
            brb_pkg::REQ_PUSH: begin
              if (!q_full) begin
                wr_en      = 1'b1;
                tail_next  = brb_pkg::wrap_inc(tail, cap_eff);
                count_next = count + CW'(1);
                emit_acc   = 1'b1;
              end
            end
            brb_pkg::REQ_POP: begin
              if (!q_empty) begin
                emit_data  = rd_data;
                head_next  = brb_pkg::wrap_inc(head, cap_eff);
                count_next = count - CW'(1);
                emit_acc   = 1'b1;
              end
            end
            brb_pkg::REQ_PEEK: begin
              if (!q_empty) begin
                emit_data = rd_data;
                emit_acc  = 1'b1;
              end
            end
            brb_pkg::REQ_RUN: begin
              if (run_ok) begin
                emit_data      = rd_data;
                head_next      = brb_pkg::wrap_inc(head, cap_eff);
                count_next     = count - CW'(1);
                emit_acc       = 1'b1;
                emit_last      = (amt == CW'(1));
                remaining_next = amt - CW'(1);
                if (amt != CW'(1)) begin
                  state_next = S_RUN;
                end
              end
            end
            brb_pkg::REQ_FILL: begin
              if (fill_ok) begin
                // hold the report until every byte is written
                emit           = 1'b0;
                remaining_next = amt;
                state_next     = S_FILL;
              end
            end
            brb_pkg::REQ_CLEAR: begin
              head_next  = '0;
              tail_next  = '0;
              count_next = '0;
              emit_acc   = 1'b1;
            end
            brb_pkg::REQ_STATUS: begin
              emit_acc = 1'b1;
            end
            default: begin
              emit_acc = 1'b0;
            end
          endcase
        end
      end

      S_RUN: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_data      = rd_data;
          emit_acc       = 1'b1;
          head_next      = brb_pkg::wrap_inc(head, cap_eff);
          count_next     = count - CW'(1);
          remaining_next = remaining - CW'(1);
          emit_last      = (remaining == CW'(1));
          if (remaining == CW'(1)) begin
            state_next = S_IDLE;
          end
        end
      end

      S_FILL: begin
        wr_en          = 1'b1;
        tail_next      = brb_pkg::wrap_inc(tail, cap_eff);
        count_next     = count + CW'(1);
        remaining_next = remaining - CW'(1);
        if (remaining == CW'(1)) begin
          state_next = S_REPORT;
        end
      end

      S_REPORT: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_acc   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      remaining <= '0;
      cap_eff   <= brb_pkg::eff_cap(brb_pkg::CAP_RESET, DEPTH);
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      remaining <= remaining_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      // Capacity write empties the ring so the pointers stay inside it
      if (cfg_wr_en) begin
        cap_eff <= brb_pkg::eff_cap(cfg_wr_data, DEPTH);
        head    <= '0;
        tail    <= '0;
        count   <= '0;
      end
    end
  end

  // Latch the request on its transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req <= req_type;
      din <= data_in;
      amt <= amount;
    end
  end

  // Result register: status reflects the queue after this result
  always_ff @(posedge clk) begin
    if (emit) begin
      data_out   <= emit_data;
      accepted   <= emit_acc;
      fill_level <= count_next;
      free_space <= cap_eff - count_next;
      is_empty   <= (count_next == '0);
      is_full    <= (count_next >= cap_eff);
      last       <= emit_last;
    end
  end

endmodule

FILE: hdl/brb_ram.sv
// Byte store of the ring: one write port, one read port, registered read data.
// Depends on brb_pkg for the byte width and the default depth.
module brb_ram #(
  parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  logic [brb_pkg::BYTE_W-1:0]   wr_data,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr,
  output logic [brb_pkg::BYTE_W-1:0]   rd_data
);

  logic [brb_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hdl/brb_chk.sv
// Port-level checker for the byte ring buffer FIFO, with its bind to the top level.
// Depends on brb_pkg for field widths.
module brb_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [brb_pkg::BYTE_W-1:0] data_out,
  input logic                       accepted,
  input logic [brb_pkg::CNT_W-1:0]  fill_level,
  input logic [brb_pkg::CNT_W-1:0]  free_space,
  input logic                       is_empty,
  input logic                       is_full,
  input logic                       last
);

  // Held result does not move under stall
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_out) && $stable(fill_level) &&
    $stable(last) && $stable(accepted))
    else $error("result changed while stalled");

  // One request at a time: a transfer closes the input until it is done
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while another is in progress");

  // Rejection is a single zero-data result
  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> last && (data_out == '0))
    else $error("rejected result malformed");

  // Empty flag follows the level
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (fill_level == '0)))
    else $error("empty flag disagrees with level");

  // Full flag follows the free space
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_full == (free_space == '0)))
    else $error("full flag disagrees with free space");

endmodule

bind byte_ring_buffer_fifo brb_chk u_brb_chk (.*);
